FILE: sv/hvt_pkg.sv
package hvt_pkg;

    localparam int COORD_W    = 32;
    localparam int COEF_W     = 16;
    localparam int COEF_FRAC  = 12;
    localparam int NUM_COLS   = 4;
    localparam int PROD_W     = COORD_W + COEF_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int SHIFT_W    = SUM_W - COEF_FRAC;
    localparam int ROW_W      = COEF_W * NUM_COLS;
    localparam int CFG_IDX_W  = 3;

    localparam logic signed [COORD_W-1:0] FIX_ONE = 32'sd65536;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ROW0         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW1         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW2         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW3         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_WEIGHT = 3'd4;

    // identity matrix rows, Q4.12
    localparam logic [ROW_W-1:0] ROW0_RESET = 64'h0000_0000_0000_1000;
    localparam logic [ROW_W-1:0] ROW1_RESET = 64'h0000_0000_1000_0000;
    localparam logic [ROW_W-1:0] ROW2_RESET = 64'h0000_1000_0000_0000;
    localparam logic [ROW_W-1:0] ROW3_RESET = 64'h1000_0000_0000_0000;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [NUM_COLS-1:0][COORD_W-1:0] t_col;

    typedef struct packed {
        logic   mode;
        t_coord in_x;
        t_coord in_y;
        t_coord in_z;
    } t_hvt_in;

    typedef struct packed {
        t_coord out_x;
        t_coord out_y;
        t_coord out_z;
        t_coord out_w;
        logic   w_not_one;
    } t_hvt_out;

    // stage load enables shared by all row pipes
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_hvt_adv;

endpackage

FILE: sv/homogeneous_vertex_transform.sv
// homogeneous 4x4 transform of a stream of vertices. each transaction carries
// x, y, z (signed q16.16) and a mode bit: points take w from the point_weight
// register, vectors take w as zero. the four matrix rows (signed q4.12, column 0
// in the low bits) are dotted with (x, y, z, w), shifted right by 12 with floor
// rounding and saturated to 32 bits. w_not_one is set for vectors whose w row
// result is not 1.0. one transaction is taken every cycle while the output is
// not stalled; a result passes one register stage each for the products, the
// row sums and the shift/saturate. registers may only be written while no
// transaction is in flight; they reset to the identity matrix and w = 1.0
module homogeneous_vertex_transform (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  hvt_pkg::t_hvt_in                 i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output hvt_pkg::t_hvt_out                o_out_data,
    input  logic                             i_cfg_we,
    input  logic [hvt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [hvt_pkg::ROW_W-1:0]        i_cfg_data
);
    import hvt_pkg::*;

    // configuration registers
    logic [ROW_W-1:0] r_row_coefs [NUM_COLS];
    t_coord           r_point_weight;

    // pipeline control: valid bit and mode per stage
    logic     r_v1, r_v2, r_v3;
    logic     n_v1, n_v2, n_v3;
    logic     r_mode1, r_mode2, r_mode3;
    t_hvt_adv w_adv;
    t_col     w_col;
    t_coord   w_row_out [NUM_COLS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_coefs[0] <= ROW0_RESET;
            r_row_coefs[1] <= ROW1_RESET;
            r_row_coefs[2] <= ROW2_RESET;
            r_row_coefs[3] <= ROW3_RESET;
            r_point_weight <= FIX_ONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROW0:         r_row_coefs[0] <= i_cfg_data;
                CFG_ROW1:         r_row_coefs[1] <= i_cfg_data;
                CFG_ROW2:         r_row_coefs[2] <= i_cfg_data;
                CFG_ROW3:         r_row_coefs[3] <= i_cfg_data;
                CFG_POINT_WEIGHT: r_point_weight <= i_cfg_data[COORD_W-1:0];
                default:          ; // unused indexes are ignored
            endcase
        end
    end

    // a stage loads when the stage before holds data and it is empty or draining
    always_comb begin
        w_adv.s3   = r_v2 && (!r_v3 || i_out_ready);
        w_adv.s2   = r_v1 && (!r_v2 || w_adv.s3);
        o_in_ready = !r_v1 || w_adv.s2;
        w_adv.s1   = i_in_valid && o_in_ready;
        n_v1       = w_adv.s1 || (r_v1 && !w_adv.s2);
        n_v2       = w_adv.s2 || (r_v2 && !w_adv.s3);
        n_v3       = w_adv.s3 || (r_v3 && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv.s1) begin
            r_mode1 <= i_in_data.mode;
        end
        if (w_adv.s2) begin
            r_mode2 <= r_mode1;
        end
        if (w_adv.s3) begin
            r_mode3 <= r_mode2;
        end
    end

    // homogeneous column: vectors carry no translation
    always_comb begin
        w_col[0] = i_in_data.in_x;
        w_col[1] = i_in_data.in_y;
        w_col[2] = i_in_data.in_z;
        w_col[3] = i_in_data.mode ? '0 : r_point_weight;
    end

    for (genvar g = 0; g < NUM_COLS; g++) begin : g_row
        hvt_row_pipe u_row (
            .i_clk    (i_clk),
            .i_adv    (w_adv),
            .i_coefs  (r_row_coefs[g]),
            .i_col    (w_col),
            .o_result (w_row_out[g])
        );
    end

    // output register is the last stage of the row pipes
    assign o_out_valid          = r_v3;
    assign o_out_data.out_x     = w_row_out[0];
    assign o_out_data.out_y     = w_row_out[1];
    assign o_out_data.out_z     = w_row_out[2];
    assign o_out_data.out_w     = w_row_out[3];
    assign o_out_data.w_not_one = r_mode3 && (w_row_out[3] != FIX_ONE);

    // a full stage is never overwritten unless it drains in the same cycle
    a_no_overwrite_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !w_adv.s3) |-> !w_adv.s2)
        else $error("stage 2 overwritten while stalled");

    a_accept_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> (!r_v1 || w_adv.s2))
        else $error("transaction accepted without room in stage 1");

    a_flag_vector_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.w_not_one) |-> r_mode3)
        else $error("w flag raised for a point");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_v1 && !r_v2 && !r_v3))
        else $error("pipeline not empty after reset");

endmodule

FILE: sv/hvt_row_pipe.sv
module hvt_row_pipe (
    input  logic                          i_clk,
    input  hvt_pkg::t_hvt_adv             i_adv,
    input  logic [hvt_pkg::ROW_W-1:0]     i_coefs,
    input  hvt_pkg::t_col                 i_col,
    output hvt_pkg::t_coord               o_result
);
    import hvt_pkg::*;

    logic signed [PROD_W-1:0]  n_prod [NUM_COLS];
    logic signed [PROD_W-1:0]  r_prod [NUM_COLS];
    logic signed [SUM_W-1:0]   n_sum;
    logic signed [SUM_W-1:0]   r_sum;
    logic signed [SHIFT_W-1:0] w_shift;
    t_coord                    n_result;
    t_coord                    r_result;

    // stage 1: one 16x32 product per column
    always_comb begin
        for (int k = 0; k < NUM_COLS; k++) begin
            n_prod[k] = PROD_W'($signed(i_coefs[COEF_W*k +: COEF_W]))
                      * PROD_W'($signed(i_col[k]));
        end
    end

    // stage 2: full width row sum
    always_comb begin
        n_sum = '0;
        for (int k = 0; k < NUM_COLS; k++) begin
            n_sum = n_sum + SUM_W'(r_prod[k]);
        end
    end

    // stage 3: floor shift back to q16.16 and saturate
    always_comb begin
        w_shift = SHIFT_W'(r_sum >>> COEF_FRAC);
        if (w_shift[SHIFT_W-1:COORD_W-1] == '0 || w_shift[SHIFT_W-1:COORD_W-1] == '1) begin
            n_result = w_shift[COORD_W-1:0];
        end else if (w_shift[SHIFT_W-1]) begin
            n_result = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            n_result = {1'b0, {(COORD_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s1) begin
            r_prod <= n_prod;
        end
        if (i_adv.s2) begin
            r_sum <= n_sum;
        end
        if (i_adv.s3) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule
